// ===== hdl/nzbw_pkg.sv =====
// Nested zone blend weights: shared widths, command/status structs, codes.
// No dependencies; imported by every other file of the block but nzbw_ram.
package nzbw_pkg;

   localparam int COORD_W   = 24;
   localparam int RAD_W     = 24;
   localparam int ZIDX_W    = 4;
   localparam int CNT_W     = 5;
   localparam int WEIGHT_W  = 17;
   localparam int FRAC_W    = 16;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int D2_W      = 2 * DIFF_W;
   localparam int SQIN_W    = D2_W + 8;
   localparam int ROOT_W    = SQIN_W / 2;
   localparam int SREM_W    = ROOT_W + 3;
   localparam int DEN_W     = RAD_W + 4;
   localparam int ENTRY_W   = 3 * COORD_W + 2 * RAD_W;
   localparam int STEP_W    = 5;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;

   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(FRAC_W - 1);

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // square/accumulate sequence
   localparam logic [2:0] SQ_DX   = 3'd0;
   localparam logic [2:0] SQ_DY   = 3'd1;
   localparam logic [2:0] SQ_DZ   = 3'd2;
   localparam logic [2:0] SQ_IN   = 3'd3;
   localparam logic [2:0] SQ_OUT  = 3'd4;
   localparam logic [2:0] SQ_DONE = 3'd5;

   typedef enum logic [1:0] {
      WSEL_ONE,
      WSEL_ZERO,
      WSEL_COMP,
      WSEL_SCALE
   } wsel_type;

   typedef struct packed {
      logic       zone_we;
      logic       mul_en;
      logic [2:0] mstep;
      logic       q_clear;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       w_we;
      wsel_type   w_sel;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic in_core;
      logic between;
   } dp_stat_type;

endpackage

// ===== hdl/nzbw_if.sv =====
// Channel interfaces: request, response and register write.
// Depends on nzbw_pkg.
interface nzbw_req_if import nzbw_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [ZIDX_W-1:0]         zone_index;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic [RAD_W-1:0]          inner_radius;
   logic [RAD_W-1:0]          outer_radius;
   modport source (output valid, req_type, zone_index, pos_x, pos_y, pos_z,
                   inner_radius, outer_radius, input ready);
   modport sink   (input valid, req_type, zone_index, pos_x, pos_y, pos_z,
                   inner_radius, outer_radius, output ready);
endinterface

interface nzbw_rsp_if import nzbw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ZIDX_W-1:0]   out_zone;
   logic [WEIGHT_W-1:0] weight;
   logic                last;
   modport source (output valid, out_zone, weight, last, input ready);
   modport sink   (input valid, out_zone, weight, last, output ready);
endinterface

interface nzbw_csr_if import nzbw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] zone_count;
   modport source (output valid, zone_count, input ready);
   modport sink   (input valid, zone_count, output ready);
endinterface

// ===== hdl/nzbw_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module nzbw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/nzbw_datapath.sv =====
// Datapath: zone and weight RAMs, shared squarer, bit-serial sqrt and divider.
// Depends on nzbw_pkg and nzbw_ram; driven by nzbw_ctrl commands.
module nzbw_datapath import nzbw_pkg::*; #(
   parameter int MAX_ZONES = 16,
   localparam int ZW = $clog2(MAX_ZONES)
) (
   input  logic                      clock,
   input  logic                      req_fire,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   input  logic [RAD_W-1:0]          req_inner,
   input  logic [RAD_W-1:0]          req_outer,
   input  dp_cmd_type                cmd,
   input  logic [ZW-1:0]             zone_addr,
   input  logic [ZW-1:0]             w_raddr,
   input  logic [ZW-1:0]             w_waddr,
   output dp_stat_type               stat,
   output logic [WEIGHT_W-1:0]       rsp_weight
);
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic [RAD_W-1:0]          pin_ff, pout_ff;
   logic [ENTRY_W-1:0]        zone_rdata;
   logic signed [COORD_W-1:0] cx, cy, cz;
   logic [RAD_W-1:0]          ci, co;
   logic signed [DIFF_W-1:0]  dx, dy, dz;
   logic [DIFF_W-1:0]         ax, ay, az, op;
   logic [D2_W-1:0]           prod_ff, d2_ff, in2_ff, out2_ff;
   logic [SQIN_W-1:0]         sx_ff;
   logic [SREM_W-1:0]         srem_ff, srem_sh, trial;
   logic [ROOT_W-1:0]         root_ff;
   logic [DEN_W-1:0]          den, num, drem_ff;
   logic [DEN_W:0]            drem_sh;
   logic [FRAC_W-1:0]         q_ff;
   logic [WEIGHT_W-1:0]       w_rdata, w_wdata, rsp_weight_ff;
   logic [WEIGHT_W+FRAC_W-1:0] scaled;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         pz_ff   <= req_pos_z;
         pin_ff  <= req_inner;
         pout_ff <= req_outer;
      end
   end

   nzbw_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ZONES)) u_zone_ram (
      .clock (clock),
      .we    (cmd.zone_we),
      .waddr (zone_addr),
      .wdata ({px_ff, py_ff, pz_ff, pin_ff, pout_ff}),
      .raddr (zone_addr),
      .rdata (zone_rdata)
   );

   assign {cx, cy, cz, ci, co} = zone_rdata;

   assign dx = DIFF_W'(px_ff) - DIFF_W'(cx);
   assign dy = DIFF_W'(py_ff) - DIFF_W'(cy);
   assign dz = DIFF_W'(pz_ff) - DIFF_W'(cz);
   assign ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
   assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
   assign az = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

   always_comb begin
      case (cmd.mstep)
         SQ_DX:   op = ax;
         SQ_DY:   op = ay;
         SQ_DZ:   op = az;
         SQ_IN:   op = DIFF_W'(ci);
         SQ_OUT:  op = DIFF_W'(co);
         default: op = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= op * op;
         case (cmd.mstep)
            SQ_DY:   d2_ff   <= prod_ff;
            SQ_DZ:   d2_ff   <= d2_ff + prod_ff;
            SQ_IN:   d2_ff   <= d2_ff + prod_ff;
            SQ_OUT:  in2_ff  <= prod_ff;
            SQ_DONE: out2_ff <= prod_ff;
            default: ;
         endcase
      end
   end

   assign stat.in_core = d2_ff < in2_ff;
   assign stat.between = d2_ff < out2_ff;

   // two radicand bits in and one root bit out per step
   assign srem_sh = {srem_ff[SREM_W-3:0], sx_ff[SQIN_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         sx_ff   <= {d2_ff, 8'b0};
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sx_ff <= {sx_ff[SQIN_W-3:0], 2'b00};
         if (srem_sh >= trial) begin
            srem_ff <= srem_sh - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= srem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign den     = {co - ci, 4'b0};
   assign num     = DEN_W'(root_ff - ROOT_W'({ci, 4'b0}));
   assign drem_sh = {drem_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.q_clear) begin
         q_ff <= '0;
      end else if (cmd.div_init) begin
         drem_ff <= num;
         q_ff    <= '0;
      end else if (cmd.div_step) begin
         if (drem_sh >= {1'b0, den}) begin
            drem_ff <= DEN_W'(drem_sh - {1'b0, den});
            q_ff    <= {q_ff[FRAC_W-2:0], 1'b1};
         end else begin
            drem_ff <= drem_sh[DEN_W-1:0];
            q_ff    <= {q_ff[FRAC_W-2:0], 1'b0};
         end
      end
   end

   assign scaled = w_rdata * q_ff;

   always_comb begin
      case (cmd.w_sel)
         WSEL_ONE:   w_wdata = WEIGHT_ONE;
         WSEL_ZERO:  w_wdata = '0;
         WSEL_COMP:  w_wdata = WEIGHT_ONE - WEIGHT_W'(q_ff);
         WSEL_SCALE: w_wdata = scaled[WEIGHT_W+FRAC_W-1:FRAC_W];
         default:    w_wdata = '0;
      endcase
   end

   nzbw_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_ZONES)) u_weight_ram (
      .clock (clock),
      .we    (cmd.w_we),
      .waddr (w_waddr),
      .wdata (w_wdata),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_weight_ff <= w_rdata;
      end
   end

   assign rsp_weight = rsp_weight_ff;
endmodule

// ===== hdl/nzbw_ctrl.sv =====
// Controller: request decode, zone walk sequencing, response handshake.
// Depends on nzbw_pkg; commands nzbw_datapath.
module nzbw_ctrl import nzbw_pkg::*; #(
   parameter int MAX_ZONES = 16,
   localparam int ZW = $clog2(MAX_ZONES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CNT_W-1:0]  csr_zone_count,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [ZIDX_W-1:0] req_zone_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ZIDX_W-1:0] rsp_out_zone,
   output logic              rsp_last,
   input  dp_stat_type       stat,
   output dp_cmd_type        cmd,
   output logic [ZW-1:0]     zone_addr,
   output logic [ZW-1:0]     w_raddr,
   output logic [ZW-1:0]     w_waddr
);
   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_QINIT, S_ZREAD, S_SQUARE, S_CLASSIFY, S_SQRT, S_DIVSET,
      S_DIV, S_ZONEWR, S_PROPRD, S_PROPWR, S_NEXT, S_EMITRD, S_EMITLD, S_EMITWAIT
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ZW-1:0]     last_ff, zi_ff, pj_ff;
   logic [STEP_W-1:0] step_ff;
   logic              load_ok_ff, req_ready_ff, rsp_valid_ff, rsp_last_ff;
   logic [ZIDX_W-1:0] rsp_zone_ff;

   assign csr_ready    = 1'b1;
   assign req_ready    = req_ready_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_out_zone = rsp_zone_ff;
   assign zone_addr    = zi_ff;
   assign w_raddr      = pj_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNT_W'(1);
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         load_ok_ff   <= 1'b0;
         step_ff      <= '0;
         last_ff      <= '0;
         zi_ff        <= '0;
         pj_ff        <= '0;
         rsp_zone_ff  <= '0;
      end else begin
         if (csr_valid) begin
            count_ff <= csr_zone_count;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  req_ready_ff <= 1'b0;
                  if (req_type == REQ_LOAD) begin
                     zi_ff      <= ZW'(req_zone_index);
                     load_ok_ff <= int'(req_zone_index) < MAX_ZONES;
                     state_ff   <= S_LOAD;
                  end else begin
                     if (count_ff == '0) begin
                        last_ff <= '0;
                     end else if (int'(count_ff) > MAX_ZONES) begin
                        last_ff <= ZW'(MAX_ZONES - 1);
                     end else begin
                        last_ff <= ZW'(count_ff - CNT_W'(1));
                     end
                     state_ff <= S_QINIT;
                  end
               end
            end
            S_LOAD: begin
               req_ready_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_QINIT: begin
               if (last_ff == '0) begin
                  pj_ff    <= '0;
                  state_ff <= S_EMITRD;
               end else begin
                  zi_ff    <= last_ff - ZW'(1);
                  state_ff <= S_ZREAD;
               end
            end
            S_ZREAD: begin
               step_ff  <= '0;
               state_ff <= S_SQUARE;
            end
            S_SQUARE: begin
               if (step_ff[2:0] == SQ_DONE) begin
                  step_ff  <= '0;
                  state_ff <= S_CLASSIFY;
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            S_CLASSIFY: begin
               if (stat.in_core) begin
                  state_ff <= S_ZONEWR;
               end else if (stat.between) begin
                  state_ff <= S_SQRT;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_SQRT: begin
               if (step_ff == SQRT_LAST) begin
                  step_ff  <= '0;
                  state_ff <= S_DIVSET;
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            S_DIVSET: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (step_ff == DIV_LAST) begin
                  step_ff  <= '0;
                  state_ff <= S_ZONEWR;
               end else begin
                  step_ff <= step_ff + STEP_W'(1);
               end
            end
            S_ZONEWR: begin
               pj_ff    <= zi_ff + ZW'(1);
               state_ff <= S_PROPRD;
            end
            S_PROPRD: begin
               state_ff <= S_PROPWR;
            end
            S_PROPWR: begin
               if (pj_ff == last_ff) begin
                  state_ff <= S_NEXT;
               end else begin
                  pj_ff    <= pj_ff + ZW'(1);
                  state_ff <= S_PROPRD;
               end
            end
            S_NEXT: begin
               if (zi_ff == '0) begin
                  pj_ff    <= '0;
                  state_ff <= S_EMITRD;
               end else begin
                  zi_ff    <= zi_ff - ZW'(1);
                  state_ff <= S_ZREAD;
               end
            end
            S_EMITRD: begin
               state_ff <= S_EMITLD;
            end
            S_EMITLD: begin
               rsp_valid_ff <= 1'b1;
               rsp_zone_ff  <= ZIDX_W'(pj_ff);
               rsp_last_ff  <= pj_ff == last_ff;
               state_ff     <= S_EMITWAIT;
            end
            S_EMITWAIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     req_ready_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     pj_ff    <= pj_ff + ZW'(1);
                     state_ff <= S_EMITRD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.w_sel = WSEL_ZERO;
      w_waddr   = zi_ff;
      case (state_ff)
         S_LOAD: begin
            cmd.zone_we = load_ok_ff;
         end
         S_QINIT: begin
            cmd.w_we  = 1'b1;
            cmd.w_sel = WSEL_ONE;
            w_waddr   = last_ff;
         end
         S_SQUARE: begin
            cmd.mul_en = 1'b1;
            cmd.mstep  = step_ff[2:0];
         end
         S_CLASSIFY: begin
            if (stat.in_core) begin
               cmd.q_clear = 1'b1;
            end else if (stat.between) begin
               cmd.sqrt_init = 1'b1;
            end else begin
               cmd.w_we = 1'b1;
            end
         end
         S_SQRT:   cmd.sqrt_step = 1'b1;
         S_DIVSET: cmd.div_init  = 1'b1;
         S_DIV:    cmd.div_step  = 1'b1;
         S_ZONEWR: begin
            cmd.w_we  = 1'b1;
            cmd.w_sel = WSEL_COMP;
         end
         S_PROPWR: begin
            cmd.w_we  = 1'b1;
            cmd.w_sel = WSEL_SCALE;
            w_waddr   = pj_ff;
         end
         S_EMITLD: cmd.rsp_load = 1'b1;
         default: ;
      endcase
   end
endmodule

// ===== hdl/nested_zone_blend_weights_top.sv =====
// Top level of the nested zone blend weight engine.
// Depends on nzbw_pkg, nzbw_if, nzbw_ctrl, nzbw_datapath, nzbw_ram.
//
//   channel  dir  payload                                           accepted on
//   csr_ch   in   zone_count                                        valid & ready
//   req_ch   in   req_type zone_index pos_x/y/z inner/outer_radius  valid & ready
//   rsp_ch   out  out_zone weight last                              valid & ready
//
// A load writes one zone RAM entry if its index is in range. A query sets the last
// zone's weight to one, then walks the lower zones downward: outside the outer radius
// a zone's weight is set to zero, else it is set and the weights of later zones scaled;
// between the radii the bit-serial square root (29 steps) and divider (16 steps) serve.
// One request is in work at a time; req_ch is not ready until the last
// response of a query is taken. rsp_ch stalls hold the engine.
// Reset (synchronous, high) sets zone_count to 1; zone RAMs are not cleared.
module nested_zone_blend_weights_top import nzbw_pkg::*; #(
   parameter int MAX_ZONES = 16
) (
   input  logic             clock,
   input  logic             reset,
   nzbw_csr_if.sink         csr_ch,
   nzbw_req_if.sink         req_ch,
   nzbw_rsp_if.source       rsp_ch
);
   localparam int ZW = $clog2(MAX_ZONES);

   dp_cmd_type    cmd;
   dp_stat_type   stat;
   logic [ZW-1:0] zone_addr, w_raddr, w_waddr;
   logic          req_fire;

   assign req_fire = req_ch.valid & req_ch.ready;

   nzbw_ctrl #(.MAX_ZONES(MAX_ZONES)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_ch.valid),
      .csr_ready      (csr_ch.ready),
      .csr_zone_count (csr_ch.zone_count),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_type       (req_ch.req_type),
      .req_zone_index (req_ch.zone_index),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_out_zone   (rsp_ch.out_zone),
      .rsp_last       (rsp_ch.last),
      .stat           (stat),
      .cmd            (cmd),
      .zone_addr      (zone_addr),
      .w_raddr        (w_raddr),
      .w_waddr        (w_waddr)
   );

   nzbw_datapath #(.MAX_ZONES(MAX_ZONES)) u_datapath (
      .clock      (clock),
      .req_fire   (req_fire),
      .req_pos_x  (req_ch.pos_x),
      .req_pos_y  (req_ch.pos_y),
      .req_pos_z  (req_ch.pos_z),
      .req_inner  (req_ch.inner_radius),
      .req_outer  (req_ch.outer_radius),
      .cmd        (cmd),
      .zone_addr  (zone_addr),
      .w_raddr    (w_raddr),
      .w_waddr    (w_waddr),
      .stat       (stat),
      .rsp_weight (rsp_ch.weight)
   );
endmodule

// ===== hdl/nzbw_checker.sv =====
// Port-level checks for the blend weight engine, bound to the top level.
// Depends on nzbw_pkg and nested_zone_blend_weights_top.
module nzbw_checker import nzbw_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [ZIDX_W-1:0]   rsp_out_zone,
   input logic [WEIGHT_W-1:0] rsp_weight,
   input logic                rsp_last
);
   // no new request while responses are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while responses pending");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weight <= WEIGHT_ONE)
      else $error("weight above one");

   // zones of a query come out in ascending order
   a_zone_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !rsp_valid ##2
      rsp_out_zone == $past(rsp_out_zone, 3) + ZIDX_W'(1))
      else $error("zone order broken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weight))
      else $error("response dropped under stall");
endmodule

bind nested_zone_blend_weights_top nzbw_checker u_nzbw_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_out_zone (rsp_ch.out_zone),
   .rsp_weight   (rsp_ch.weight),
   .rsp_last     (rsp_ch.last)
);
